>>> rtl/core/wso_pkg.sv
// Shared types, constants and calendar helpers for the weekly schedule
// occurrence unit. No dependencies.
`default_nettype none

package wso_pkg;

  typedef struct packed {
    logic       command;
    logic [4:0] sched_hour;
    logic [5:0] sched_minute;
    logic [6:0] sched_days;
    logic       sched_enabled;
    logic [13:0] now_year;
    logic [3:0] now_month;
    logic [4:0] now_day;
    logic [2:0] now_weekday;
    logic [4:0] now_hour;
    logic [5:0] now_minute;
    logic [5:0] now_second;
  } req_t;

  typedef struct packed {
    logic [13:0] occ_year;
    logic [3:0] occ_month;
    logic [4:0] occ_day;
    logic [2:0] occ_weekday;
    logic [4:0] occ_hour;
    logic [5:0] occ_minute;
  } occ_t;

  // controller -> datapath
  typedef struct packed {
    logic load;
    logic calc_rem;
    logic step;
    logic publish;
  } dp_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic pre_step;
    logic disabled;
    logic match;
  } dp_stat_t;

  localparam logic       CmdNext     = 1'b0;
  localparam logic [3:0] SearchSteps = 4'd8;
  localparam logic [3:0] LastMonth   = 4'd11;
  localparam logic [4:0] MonthsPerYr = 5'd12;
  localparam logic [3:0] DaysPerWeek = 4'd7;
  localparam logic [2:0] LastDow     = 3'd6;
  localparam logic [6:0] SundayBit   = 7'h40;

  // year mod 400 by reciprocal: floor(y * 5243 / 2^21) == floor(y / 400) for 14-bit y
  localparam logic [26:0] Recip400  = 27'd5243;
  localparam int unsigned RecipShift = 21;
  localparam logic [13:0] Cycle400   = 14'd400;
  localparam logic [8:0]  LastRem    = 9'd399;
  localparam logic [8:0]  MaxYearRem = 9'd383;   // 16383 mod 400
  localparam logic [13:0] MaxYear    = 14'h3FFF;
  localparam logic [8:0]  Cent1 = 9'd100;
  localparam logic [8:0]  Cent2 = 9'd200;
  localparam logic [8:0]  Cent3 = 9'd300;

  localparam logic [3:0] MonFeb = 4'd1;
  localparam logic [3:0] MonApr = 4'd3;
  localparam logic [3:0] MonJun = 4'd5;
  localparam logic [3:0] MonSep = 4'd8;
  localparam logic [3:0] MonNov = 4'd10;
  localparam logic [3:0] Mon12  = 4'd12;
  localparam logic [3:0] Mon15  = 4'd15;

  function automatic logic [4:0] month_len(input logic [3:0] m, input logic leap);
    logic [4:0] len;
    case (m)
      MonFeb: len = leap ? 5'd29 : 5'd28;
      MonApr, MonJun, MonSep, MonNov, Mon12, Mon15: len = 5'd30;
      default: len = 5'd31;
    endcase
    return len;
  endfunction

endpackage

`default_nettype wire

>>> rtl/core/wso_if.sv
// Valid/ready channel interfaces for request and occurrence payloads.
// Depends on wso_pkg.
`default_nettype none

interface wso_req_if;
  import wso_pkg::*;
  logic valid;
  logic ready;
  req_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface wso_occ_if;
  import wso_pkg::*;
  logic valid;
  logic ready;
  occ_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

>>> rtl/core/wso_dpath.sv
// Datapath: request registers, year-mod-400 unit, one-day calendar stepper
// and output payload register. Depends on wso_pkg.
`default_nettype none

module wso_dpath (
  input  logic              clk,
  input  wso_pkg::req_t     req_data,
  input  wso_pkg::dp_cmd_t  cmd,
  output wso_pkg::dp_stat_t stat,
  output wso_pkg::occ_t     occ_data
);
  import wso_pkg::*;

  logic        dir_back_r;
  logic [4:0]  hour_r;
  logic [5:0]  minute_r;
  logic [6:0]  mask_r;
  logic        disabled_r;
  logic        pre_r;
  logic [13:0] year_r;
  logic [3:0]  month_r;
  logic [4:0]  day_r;
  logic [2:0]  dow_r;
  logic [5:0]  quo_r;
  logic [8:0]  rem_r;
  occ_t        occ_r;

  logic [13:0] year_nxt;
  logic [3:0]  month_nxt;
  logic [4:0]  day_nxt;
  logic [2:0]  dow_nxt;
  logic [8:0]  rem_nxt;

  logic [16:0] sched_t;
  logic [16:0] now_t;
  logic [26:0] quo_prod;
  logic [13:0] quo_times;
  logic [13:0] rem_full;
  logic        leap;
  logic [4:0]  mlen_cur;
  logic [4:0]  mlen_prev;
  logic [3:0]  month_dec;
  logic [4:0]  month_inc;
  logic [5:0]  day_inc;
  logic [3:0]  dow_inc;

  assign sched_t  = {req_data.sched_hour, req_data.sched_minute, 6'd0};
  assign now_t    = {req_data.now_hour, req_data.now_minute, req_data.now_second};
  assign quo_prod = {13'd0, req_data.now_year} * Recip400;

  assign quo_times = 14'({8'd0, quo_r} * Cycle400);
  assign rem_full  = year_r - quo_times;

  assign leap = (year_r[1:0] == 2'b00) && (rem_r != Cent1) && (rem_r != Cent2) &&
                (rem_r != Cent3);
  assign mlen_cur  = month_len(month_r, leap);
  assign month_dec = (month_r == 4'd0) ? LastMonth : month_r - 4'd1;
  assign mlen_prev = month_len(month_dec, leap);  // leap only matters for Feb, same year
  assign month_inc = {1'b0, month_r} + 5'd1;
  assign day_inc   = {1'b0, day_r} + 6'd1;
  assign dow_inc   = {1'b0, dow_r} + 4'd1;

  always_comb begin
    year_nxt  = year_r;
    month_nxt = month_r;
    day_nxt   = day_r;
    dow_nxt   = dow_r;
    rem_nxt   = rem_r;
    if (!dir_back_r) begin
      // weekday 7 lands on Monday after a step, like a mod-7 reduction
      dow_nxt = (dow_inc >= DaysPerWeek) ? 3'(dow_inc - DaysPerWeek) : dow_inc[2:0];
      if (day_inc >= {1'b0, mlen_cur}) begin
        day_nxt = 5'(day_inc - {1'b0, mlen_cur});
        if (month_inc >= MonthsPerYr) begin
          month_nxt = 4'(month_inc - MonthsPerYr);
          year_nxt  = year_r + 14'd1;
          if (year_r == MaxYear || rem_r == LastRem) begin
            rem_nxt = 9'd0;
          end else begin
            rem_nxt = rem_r + 9'd1;
          end
        end else begin
          month_nxt = month_inc[3:0];
        end
      end else begin
        day_nxt = day_inc[4:0];
      end
    end else begin
      dow_nxt = (dow_r == 3'd0) ? LastDow : dow_r - 3'd1;
      if (day_r == 5'd0) begin
        month_nxt = month_dec;
        day_nxt   = mlen_prev - 5'd1;
        if (month_r == 4'd0) begin
          year_nxt = year_r - 14'd1;
          if (year_r == 14'd0) begin
            rem_nxt = MaxYearRem;
          end else if (rem_r == 9'd0) begin
            rem_nxt = LastRem;
          end else begin
            rem_nxt = rem_r - 9'd1;
          end
        end
      end else begin
        day_nxt = day_r - 5'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      dir_back_r <= req_data.command;
      hour_r     <= req_data.sched_hour;
      minute_r   <= req_data.sched_minute;
      mask_r     <= req_data.sched_days;
      disabled_r <= (req_data.sched_days == 7'd0) || !req_data.sched_enabled;
      pre_r      <= (req_data.command == CmdNext) ? (sched_t < now_t) : (sched_t > now_t);
      year_r     <= req_data.now_year;
      month_r    <= req_data.now_month;
      day_r      <= req_data.now_day;
      dow_r      <= req_data.now_weekday;
      quo_r      <= quo_prod[RecipShift +: 6];
    end else if (cmd.calc_rem) begin
      rem_r <= rem_full[8:0];
    end else if (cmd.step) begin
      year_r  <= year_nxt;
      month_r <= month_nxt;
      day_r   <= day_nxt;
      dow_r   <= dow_nxt;
      rem_r   <= rem_nxt;
    end
    if (cmd.publish) begin
      occ_r.occ_year    <= year_r;
      occ_r.occ_month   <= month_r;
      occ_r.occ_day     <= day_r;
      occ_r.occ_weekday <= dow_r;
      occ_r.occ_hour    <= hour_r;
      occ_r.occ_minute  <= minute_r;
    end
  end

  assign stat.pre_step = pre_r && !disabled_r;
  assign stat.disabled = disabled_r;
  assign stat.match    = |((SundayBit >> dow_r) & mask_r);  // weekday 7 shifts out
  assign occ_data      = occ_r;

endmodule

`default_nettype wire

>>> rtl/core/wso_ctrl.sv
// Controller: sequences load, remainder, pre-step, day search and publish,
// and owns the output valid flag. Depends on wso_pkg.
`default_nettype none

module wso_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  input  wso_pkg::dp_stat_t stat,
  output wso_pkg::dp_cmd_t  cmd
);
  import wso_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_REM,
    ST_PRE,
    ST_SRCH,
    ST_DONE
  } state_t;

  state_t     state_r, state_nxt;
  logic [3:0] cnt_r, cnt_nxt;
  logic       out_valid_r, out_valid_nxt;

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    cmd       = '0;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = ST_REM;
        end
      end
      ST_REM: begin
        cmd.calc_rem = 1'b1;
        state_nxt    = ST_PRE;
      end
      ST_PRE: begin
        cmd.step  = stat.pre_step;
        cnt_nxt   = 4'd0;
        state_nxt = ST_SRCH;
      end
      ST_SRCH: begin
        // disabled schedules ignore the mask and take all eight steps
        if (cnt_r == SearchSteps || (!stat.disabled && stat.match)) begin
          state_nxt = ST_DONE;
        end else begin
          cmd.step = 1'b1;
          cnt_nxt  = cnt_r + 4'd1;
        end
      end
      ST_DONE: begin
        if (!out_valid_r || out_ready) begin
          cmd.publish = 1'b1;
          state_nxt   = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
    out_valid_nxt = cmd.publish || (out_valid_r && !out_ready);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_r       <= 4'd0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_ready  = (state_r == ST_IDLE);
  assign out_valid = out_valid_r;

endmodule

`default_nettype wire

>>> rtl/core/weekly_schedule_occurrence_unit.sv
// Sequence: a taken request passes through the remainder, pre-step, day search
//   (k = days stepped in the search loop, 0..8; disabled schedules always 8) and
//   publish states before the result becomes valid; publish waits while the output stalls.
// Requests: one at a time; the day stepper advances one calendar day per
//   cycle. A finished result waits in the output register while the next
//   request is taken.
// Reset (rst_n low, synchronous) clears the controller and output valid.
`default_nettype none

module weekly_schedule_occurrence_unit (
  input  logic             clk,
  input  logic             rst_n,
  wso_req_if.sink          in_req,
  wso_occ_if.source        out_occ
);
  import wso_pkg::*;

  dp_cmd_t  cmd;
  dp_stat_t stat;

  wso_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_req.valid),
    .in_ready  (in_req.ready),
    .out_valid (out_occ.valid),
    .out_ready (out_occ.ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  wso_dpath u_dpath (
    .clk      (clk),
    .req_data (in_req.data),
    .cmd      (cmd),
    .stat     (stat),
    .occ_data (out_occ.data)
  );

endmodule

`default_nettype wire

>>> rtl/core/wso_checker.sv
// Port-level checks for weekly_schedule_occurrence_unit, attached by bind.
// Depends on wso_pkg and the top level's channel interfaces.
`default_nettype none

module wso_checker (
  input logic          clk,
  input logic          rst_n,
  input logic          in_valid,
  input logic          in_ready,
  input logic          out_valid,
  input logic          out_ready,
  input wso_pkg::occ_t out_data
);
  import wso_pkg::*;

  logic in_acc;
  assign in_acc = in_valid && in_ready;

  a_reset_idle: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> !in_ready)
    else $error("request taken while another is in flight");

  a_min_latency: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |-> ##1 !$rose(out_valid) ##1 !$rose(out_valid))
    else $error("result appeared too soon after request");

  a_weekday_reduced: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_data.occ_weekday != 3'd7)
    else $error("occurrence weekday not reduced");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("stalled result dropped or changed");

endmodule

bind weekly_schedule_occurrence_unit wso_checker u_wso_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_req.valid),
  .in_ready  (in_req.ready),
  .out_valid (out_occ.valid),
  .out_ready (out_occ.ready),
  .out_data  (out_occ.data)
);

`default_nettype wire
